/* rtl/obot_pkg.sv */
// ----------------------------------------------------------------------------
// obot_pkg
// Shared constants and the quarter-wave sine table of the box overlap test.
// ----------------------------------------------------------------------------
`default_nettype none

package obot_pkg;

  // Fraction bits of the stored sine table
  localparam int TableFracBits = 14;
  localparam int TableWidth    = 17;  // signed width of a table value

  // Angle landmarks in degrees
  localparam logic [9:0] DEG_90  = 10'd90;
  localparam logic [9:0] DEG_180 = 10'd180;
  localparam logic [9:0] DEG_270 = 10'd270;
  localparam logic [9:0] DEG_360 = 10'd360;

  // round(16384 * sin(d)) for d = 0..90
  localparam logic [14:0] SINE_Q14 [0:90] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15963, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // Sine in Q1.14 of an angle already reduced to 0..359 degrees
  function automatic logic signed [TableWidth-1:0] sine_q14(input logic [9:0] deg);
    logic [9:0]  idx;
    logic        neg;
    logic [14:0] mag;
    if (deg <= DEG_90) begin
      idx = deg;
      neg = 1'b0;
    end else if (deg <= DEG_180) begin
      idx = DEG_180 - deg;
      neg = 1'b0;
    end else if (deg <= DEG_270) begin
      idx = deg - DEG_180;
      neg = 1'b1;
    end else begin
      idx = DEG_360 - deg;
      neg = 1'b1;
    end
    mag = SINE_Q14[idx[6:0]];
    return neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
  endfunction

endpackage

`default_nettype wire

/* rtl/obot_trig.sv */
// ----------------------------------------------------------------------------
// obot_trig
// Sine and cosine of a whole-degree angle, scaled to the working fraction bits.
// ----------------------------------------------------------------------------
`default_nettype none

module obot_trig #(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  wire logic [8:0]                  angle_i,
  output      logic signed [TRIG_FRAC_BITS+1:0] sin_o,
  output      logic signed [TRIG_FRAC_BITS+1:0] cos_o
);

  localparam int TW   = TRIG_FRAC_BITS + 2;
  localparam int TBW  = obot_pkg::TableWidth;
  localparam int UP   = (TRIG_FRAC_BITS > obot_pkg::TableFracBits) ?
                        TRIG_FRAC_BITS - obot_pkg::TableFracBits : 0;
  localparam int DN   = (TRIG_FRAC_BITS < obot_pkg::TableFracBits) ?
                        obot_pkg::TableFracBits - TRIG_FRAC_BITS : 0;
  localparam int SW   = TBW + UP + 1;
  localparam logic signed [SW-1:0] HALF =
    (DN > 0) ? (SW'(1) <<< ((DN > 0) ? DN - 1 : 0)) : '0;

  logic [9:0] ang_s;
  logic [9:0] ang_c;
  logic [9:0] ang_c_raw;
  logic signed [TBW-1:0] sin_raw;
  logic signed [TBW-1:0] cos_raw;

  // Reduce the angle and the quarter-turned angle into 0..359
  always_comb begin
    ang_s     = ({1'b0, angle_i} >= obot_pkg::DEG_360) ? {1'b0, angle_i} - obot_pkg::DEG_360
                                                       : {1'b0, angle_i};
    ang_c_raw = ang_s + obot_pkg::DEG_90;
    ang_c     = (ang_c_raw >= obot_pkg::DEG_360) ? ang_c_raw - obot_pkg::DEG_360 : ang_c_raw;
  end

  assign sin_raw = obot_pkg::sine_q14(ang_s);
  assign cos_raw = obot_pkg::sine_q14(ang_c);

  // Rescale: shift up, or round right with halves going up
  function automatic logic signed [TW-1:0] rescale(input logic signed [TBW-1:0] v);
    logic signed [SW-1:0] ext;
    logic signed [SW-1:0] rnd;
    ext = {{(SW-TBW){v[TBW-1]}}, v};
    rnd = ((ext <<< UP) + HALF) >>> DN;
    return rnd[TW-1:0];
  endfunction

  assign sin_o = rescale(sin_raw);
  assign cos_o = rescale(cos_raw);

endmodule

`default_nettype wire

/* rtl/oriented_box_overlap_test_unit.sv */
// ----------------------------------------------------------------------------
// oriented_box_overlap_test_unit
// Separating axis overlap test of two rotated rectangles, fully pipelined.
// ----------------------------------------------------------------------------
// One box pair enters per cycle unless the input is refused (see below), and its
// collide flag passes through all the register stages. The five register stages are:
// angle lookup and center difference, the eight size-times-trig products,
// rounded corners relative to the other center, the sixteen corner projections,
// and the per-axis min/max with the extent compare. A stage holds its item while
// the next one is full and not draining, so the input is refused only when all
// five stages are full and the output is stalled. Touching boxes count as colliding.
`default_nettype none

module oriented_box_overlap_test_unit #(
  parameter int COORD_BITS     = 16,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic signed [COORD_BITS-1:0] first_center_x_i,
  input  wire logic signed [COORD_BITS-1:0] first_center_y_i,
  input  wire logic [COORD_BITS-2:0]        first_width_i,
  input  wire logic [COORD_BITS-2:0]        first_height_i,
  input  wire logic [8:0]                   first_angle_deg_i,
  input  wire logic signed [COORD_BITS-1:0] second_center_x_i,
  input  wire logic signed [COORD_BITS-1:0] second_center_y_i,
  input  wire logic [COORD_BITS-2:0]        second_width_i,
  input  wire logic [COORD_BITS-2:0]        second_height_i,
  input  wire logic [8:0]                   second_angle_deg_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic                         collide_o
);

  localparam int C    = COORD_BITS;
  localparam int T    = TRIG_FRAC_BITS;
  localparam int TW   = T + 2;          // trig value
  localparam int DW   = C + 1;          // center difference
  localparam int MW   = T + C + 2;      // trig times size
  localparam int SUMW = T + C + 3;      // offset before rounding
  localparam int OW   = C + 2;          // rounded corner offset
  localparam int RW   = C + 3;          // corner relative to other center
  localparam int PW   = T + C + 6;      // projection
  localparam int CW   = PW + 1;         // doubled projection / bound
  localparam logic signed [SUMW-1:0] RHALF = SUMW'(1) <<< T;

  // Stage enables: a stage loads when empty or when it drains this cycle
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5        = !v5_q || out_ready_i;
  assign en4        = !v4_q || en5;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // ---------------- stage 1: trig lookup and center difference ----------------
  logic signed [TW-1:0] sin_d [2];
  logic signed [TW-1:0] cos_d [2];

  obot_trig #(.TRIG_FRAC_BITS(T)) u_trig_first (
    .angle_i (first_angle_deg_i),
    .sin_o   (sin_d[0]),
    .cos_o   (cos_d[0])
  );

  obot_trig #(.TRIG_FRAC_BITS(T)) u_trig_second (
    .angle_i (second_angle_deg_i),
    .sin_o   (sin_d[1]),
    .cos_o   (cos_d[1])
  );

  logic signed [TW-1:0] s1_sin_q [2];
  logic signed [TW-1:0] s1_cos_q [2];
  logic [C-2:0]         s1_w_q [2];
  logic [C-2:0]         s1_h_q [2];
  logic signed [DW-1:0] s1_dx_q, s1_dy_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_sin_q[0] <= sin_d[0];
      s1_sin_q[1] <= sin_d[1];
      s1_cos_q[0] <= cos_d[0];
      s1_cos_q[1] <= cos_d[1];
      s1_w_q[0]   <= first_width_i;
      s1_w_q[1]   <= second_width_i;
      s1_h_q[0]   <= first_height_i;
      s1_h_q[1]   <= second_height_i;
      s1_dx_q     <= {second_center_x_i[C-1], second_center_x_i}
                   - {first_center_x_i[C-1], first_center_x_i};
      s1_dy_q     <= {second_center_y_i[C-1], second_center_y_i}
                   - {first_center_y_i[C-1], first_center_y_i};
    end
  end

  // ---------------- stage 2: size times trig products ----------------
  logic signed [MW-1:0] s2_cw_q [2];
  logic signed [MW-1:0] s2_sh_q [2];
  logic signed [MW-1:0] s2_sw_q [2];
  logic signed [MW-1:0] s2_ch_q [2];
  logic signed [TW-1:0] s2_sin_q [2];
  logic signed [TW-1:0] s2_cos_q [2];
  logic [C-2:0]         s2_w_q [2];
  logic [C-2:0]         s2_h_q [2];
  logic signed [DW-1:0] s2_dx_q, s2_dy_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int b = 0; b < 2; b++) begin
        s2_cw_q[b]  <= MW'(s1_cos_q[b]) * MW'($signed({1'b0, s1_w_q[b]}));
        s2_sh_q[b]  <= MW'(s1_sin_q[b]) * MW'($signed({1'b0, s1_h_q[b]}));
        s2_sw_q[b]  <= MW'(s1_sin_q[b]) * MW'($signed({1'b0, s1_w_q[b]}));
        s2_ch_q[b]  <= MW'(s1_cos_q[b]) * MW'($signed({1'b0, s1_h_q[b]}));
        s2_sin_q[b] <= s1_sin_q[b];
        s2_cos_q[b] <= s1_cos_q[b];
        s2_w_q[b]   <= s1_w_q[b];
        s2_h_q[b]   <= s1_h_q[b];
      end
      s2_dx_q <= s1_dx_q;
      s2_dy_q <= s1_dy_q;
    end
  end

  // ---------------- stage 3: rounded corners relative to the other center -------
  logic signed [RW-1:0] rel_x_d [2][4];
  logic signed [RW-1:0] rel_y_d [2][4];

  always_comb begin
    logic signed [SUMW-1:0] cw, sh, sw, ch, ox_raw, oy_raw, ox_r, oy_r;
    logic signed [RW-1:0]   base_x, base_y;
    for (int b = 0; b < 2; b++) begin
      cw = SUMW'(s2_cw_q[b]);
      sh = SUMW'(s2_sh_q[b]);
      sw = SUMW'(s2_sw_q[b]);
      ch = SUMW'(s2_ch_q[b]);
      // second box is measured from the first center, first box from the second
      base_x = (b == 1) ? RW'(s2_dx_q) : -RW'(s2_dx_q);
      base_y = (b == 1) ? RW'(s2_dy_q) : -RW'(s2_dy_q);
      for (int k = 0; k < 4; k++) begin
        ox_raw = (k[0] ? -cw : cw) - (k[1] ? -sh : sh);
        oy_raw = (k[0] ? -sw : sw) + (k[1] ? -ch : ch);
        ox_r   = (ox_raw + RHALF) >>> (T + 1);
        oy_r   = (oy_raw + RHALF) >>> (T + 1);
        rel_x_d[b][k] = base_x + RW'($signed(ox_r[OW-1:0]));
        rel_y_d[b][k] = base_y + RW'($signed(oy_r[OW-1:0]));
      end
    end
  end

  logic signed [RW-1:0] s3_rx_q [2][4];
  logic signed [RW-1:0] s3_ry_q [2][4];
  logic signed [TW-1:0] s3_sin_q [2];
  logic signed [TW-1:0] s3_cos_q [2];
  logic [C-2:0]         s3_w_q [2];
  logic [C-2:0]         s3_h_q [2];

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_rx_q  <= rel_x_d;
      s3_ry_q  <= rel_y_d;
      s3_sin_q <= s2_sin_q;
      s3_cos_q <= s2_cos_q;
      s3_w_q   <= s2_w_q;
      s3_h_q   <= s2_h_q;
    end
  end

  // ---------------- stage 4: project the other box's corners on each axis -------
  // index: [box owning the axis][axis: 0 along width, 1 along height][corner]
  logic signed [PW-1:0] proj_d [2][2][4];

  always_comb begin
    logic signed [TW-1:0] ax, ay;
    for (int d = 0; d < 2; d++) begin
      for (int a = 0; a < 2; a++) begin
        ax = (a == 0) ? s3_cos_q[d] : -s3_sin_q[d];
        ay = (a == 0) ? s3_sin_q[d] :  s3_cos_q[d];
        for (int k = 0; k < 4; k++) begin
          proj_d[d][a][k] = PW'(ax) * PW'(s3_rx_q[1-d][k])
                          + PW'(ay) * PW'(s3_ry_q[1-d][k]);
        end
      end
    end
  end

  logic signed [PW-1:0] s4_proj_q [2][2][4];
  logic [C-2:0]         s4_w_q [2];
  logic [C-2:0]         s4_h_q [2];

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_proj_q <= proj_d;
      s4_w_q    <= s3_w_q;
      s4_h_q    <= s3_h_q;
    end
  end

  // ---------------- stage 5: interval test on all four axes ----------------
  logic hit_d;

  always_comb begin
    logic signed [PW-1:0] lo, hi;
    logic signed [CW-1:0] bnd;
    logic [C-2:0]         ext;
    hit_d = 1'b1;
    for (int d = 0; d < 2; d++) begin
      for (int a = 0; a < 2; a++) begin
        lo = s4_proj_q[d][a][0];
        hi = s4_proj_q[d][a][0];
        for (int k = 1; k < 4; k++) begin
          if (s4_proj_q[d][a][k] < lo) lo = s4_proj_q[d][a][k];
          if (s4_proj_q[d][a][k] > hi) hi = s4_proj_q[d][a][k];
        end
        ext = (a == 0) ? s4_w_q[d] : s4_h_q[d];
        bnd = $signed({{(CW-(C-1)-T){1'b0}}, ext, {T{1'b0}}});
        if (!(($signed({lo, 1'b0}) <= bnd) && ($signed({hi, 1'b0}) >= -bnd))) begin
          hit_d = 1'b0;
        end
      end
    end
  end

  logic s5_hit_q;

  always_ff @(posedge clk_i) begin
    if (en5) s5_hit_q <= hit_d;
  end

  assign out_valid_o = v5_q;
  assign collide_o   = s5_hit_q;

endmodule

`default_nettype wire

/* rtl/obot_checker.sv */
// ----------------------------------------------------------------------------
// obot_checker
// Port-level checks of the box overlap test unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module obot_checker #(
  parameter int Depth = 5
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic collide_o
);

  logic [3:0] cnt_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Track items inside the unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + {3'b000, in_acc} - {3'b000, out_acc};
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(collide_o))
    else $error("stalled result changed");

  // Show no result without an item inside
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != 4'd0)
    else $error("result without an item");

  // Never hold more items than pipeline stages
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'(Depth))
    else $error("too many items inside");

  // Refuse input only under output back pressure
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input refused without back pressure");

endmodule

bind oriented_box_overlap_test_unit obot_checker u_obot_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .collide_o   (collide_o)
);

`default_nettype wire
